// ===== hw/rtl/rne_pkg.sv =====
package rne_pkg;

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymbolW = 7;
  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  localparam logic [SymbolW-1:0] SymNone = 7'h00;
  localparam logic [SymbolW-1:0] SymM    = 7'h4D;
  localparam logic [SymbolW-1:0] SymD    = 7'h44;
  localparam logic [SymbolW-1:0] SymC    = 7'h43;
  localparam logic [SymbolW-1:0] SymL    = 7'h4C;
  localparam logic [SymbolW-1:0] SymX    = 7'h58;
  localparam logic [SymbolW-1:0] SymV    = 7'h56;
  localparam logic [SymbolW-1:0] SymI    = 7'h49;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  typedef struct packed {
    logic [ValueW-1:0]  weight;
    logic [SymbolW-1:0] first;
    logic [SymbolW-1:0] second;
    logic               pair;
  } token_t;

  // Largest numeral token that fits in the remainder
  function automatic token_t next_token(input logic [ValueW-1:0] rem);
    token_t t;
    t = '{weight: ValueW'(1), first: SymI, second: SymNone, pair: 1'b0};
    priority if (rem >= ValueW'(1000)) t = '{ValueW'(1000), SymM, SymNone, 1'b0};
    else if (rem >= ValueW'(900)) t = '{ValueW'(900), SymC, SymM, 1'b1};
    else if (rem >= ValueW'(500)) t = '{ValueW'(500), SymD, SymNone, 1'b0};
    else if (rem >= ValueW'(400)) t = '{ValueW'(400), SymC, SymD, 1'b1};
    else if (rem >= ValueW'(100)) t = '{ValueW'(100), SymC, SymNone, 1'b0};
    else if (rem >= ValueW'(90))  t = '{ValueW'(90), SymX, SymC, 1'b1};
    else if (rem >= ValueW'(50))  t = '{ValueW'(50), SymL, SymNone, 1'b0};
    else if (rem >= ValueW'(40))  t = '{ValueW'(40), SymX, SymL, 1'b1};
    else if (rem >= ValueW'(10))  t = '{ValueW'(10), SymX, SymNone, 1'b0};
    else if (rem >= ValueW'(9))   t = '{ValueW'(9), SymI, SymX, 1'b1};
    else if (rem >= ValueW'(5))   t = '{ValueW'(5), SymV, SymNone, 1'b0};
    else if (rem >= ValueW'(4))   t = '{ValueW'(4), SymI, SymV, 1'b1};
    else t = '{ValueW'(1), SymI, SymNone, 1'b0};
    return t;
  endfunction

endpackage

// ===== hw/rtl/rne_in_if.sv =====
interface rne_in_if;
  logic                        valid;
  logic                        ready;
  logic [rne_pkg::ValueW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== hw/rtl/rne_out_if.sv =====
interface rne_out_if;
  logic                        valid;
  logic                        ready;
  logic [rne_pkg::SymbolW-1:0] symbol;
  logic                        last;
  logic                        range_error;

  modport source (output valid, output symbol, output last, output range_error, input ready);
  modport sink (input valid, input symbol, input last, input range_error, output ready);
endinterface

// ===== hw/rtl/rne_ctrl.sv =====
module rne_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rne_pkg::cmd_t    cmd_o,
  input  rne_pkg::status_t sts_i
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.step = (state_q == StRun) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
          if (cmd_o.load) state_q <= StRun;
        end
        StRun: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (sts_i.last) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rne_dp.sv =====
module rne_dp (
  input  logic                        clk_i,
  input  logic [rne_pkg::ValueW-1:0]  value_i,
  input  rne_pkg::cmd_t               cmd_i,
  output rne_pkg::status_t            sts_o,
  output logic [rne_pkg::SymbolW-1:0] symbol_o,
  output logic                        last_o,
  output logic                        range_error_o
);

  logic [rne_pkg::ValueW-1:0]  rem_q, rem_d;
  logic                        err_q;
  logic                        pend_q, pend_d;
  logic [rne_pkg::SymbolW-1:0] pend_sym_q;
  logic [rne_pkg::SymbolW-1:0] sym_q, sym_d;
  logic                        last_q, last_d;
  logic                        rerr_q;
  rne_pkg::token_t             tok;
  logic [rne_pkg::ValueW-1:0]  rem_sub;

  assign tok     = rne_pkg::next_token(rem_q);
  assign rem_sub = rem_q - tok.weight;

  always_comb begin
    rem_d  = rem_q;
    pend_d = 1'b0;
    priority if (err_q) begin
      sym_d  = rne_pkg::SymNone;
      last_d = 1'b1;
    end else if (pend_q) begin
      sym_d  = pend_sym_q;
      last_d = (rem_q == '0);
    end else begin
      sym_d  = tok.first;
      rem_d  = rem_sub;
      pend_d = tok.pair;
      last_d = !tok.pair && (rem_sub == '0);
    end
  end

  assign sts_o.last = last_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q  <= value_i;
      err_q  <= (value_i == '0) || (value_i > rne_pkg::MaxValue);
      pend_q <= 1'b0;
    end else if (cmd_i.step) begin
      rem_q      <= rem_d;
      pend_q     <= pend_d;
      pend_sym_q <= tok.second;
      sym_q      <= sym_d;
      last_q     <= last_d;
      rerr_q     <= err_q;
    end
  end

  assign symbol_o      = sym_q;
  assign last_o        = last_q;
  assign range_error_o = rerr_q;

endmodule

// ===== hw/rtl/roman_numeral_encoder.sv =====
// The first character is registered from the remainder that is loaded when the item is taken; after
// that, one character per cycle while the output is not stalled. A new item is taken only in idle, once
// the last character of a run has been stepped out; an out-of-range value gives one error result. The
// remainder register and the largest-token compare in the datapath emit one character per step.
// Reset: asynchronous, active low; returns to idle with no result pending.
module roman_numeral_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  rne_in_if.sink    in_i,
  rne_out_if.source out_o
);

  rne_pkg::cmd_t    cmd;
  rne_pkg::status_t sts;

  rne_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rne_dp u_dp (
    .clk_i         (clk_i),
    .value_i       (in_i.value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .symbol_o      (out_o.symbol),
    .last_o        (out_o.last),
    .range_error_o (out_o.range_error)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.range_error |-> out_o.last && out_o.symbol == rne_pkg::SymNone)
    else $error("error item not a lone empty result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.range_error |-> out_o.symbol != rne_pkg::SymNone)
    else $error("numeral item without a symbol");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("item taken while a run is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.step)
    else $error("load and step issued together");

endmodule
